### rtl/core/cwpe_pkg.sv
// shared codes, types and helpers of the credit window packet engine
`default_nettype none
package cwpe_pkg;

    localparam int DEF_RING_SLOTS   = 8;
    localparam int DEF_SEND_BUFFERS = 2;

    localparam logic [2:0] ACT_POST    = 3'd0;
    localparam logic [2:0] ACT_SEND    = 3'd1;
    localparam logic [2:0] ACT_ARRIVE  = 3'd2;
    localparam logic [2:0] ACT_CONSUME = 3'd3;
    localparam logic [2:0] ACT_ACK     = 3'd4;

    localparam logic [2:0] ST_SENT     = 3'd0;
    localparam logic [2:0] ST_BLOCK    = 3'd1;
    localparam logic [2:0] ST_DONE     = 3'd2;
    localparam logic [2:0] ST_CONSUMED = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;
    localparam logic [2:0] ST_NONE     = 3'd5;
    localparam logic [2:0] ST_ACCEPTED = 3'd6;

    localparam logic [1:0] REG_PAYLOAD   = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_MAX_OUT   = 2'd2;

    localparam logic [12:0] PAYLOAD_RESET   = 13'd8188;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd5;
    localparam logic [3:0]  MAX_OUT_RESET   = 4'd2;

    localparam logic [15:0] CREDIT_MAX = 16'hFFFF;
    localparam logic [23:0] TOTAL_MAX  = 24'hFFFFFF;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic scan_clr;
        logic scan_rd;
        logic scan_acc;
        logic exec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } t_sts;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? CREDIT_MAX : s[15:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/cwpe_ctrl.sv
// sequencer: request capture, slot scan and execute steps
`default_nettype none
module cwpe_ctrl
    import cwpe_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PREP     = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_ACC = 3'd3;
    localparam logic [2:0] S_EXEC     = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                if (i_sts.need_scan) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN_RD;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_ACC;
            end
            S_SCAN_ACC: begin
                o_cmd.scan_acc = 1'b1;
                n_state        = i_sts.scan_last ? S_EXEC : S_SCAN_RD;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE) |=> (r_state == S_PREP))
        else $error("accepted request did not enter prep");
    a_acc_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_ACC) |-> ($past(r_state) == S_SCAN_RD))
        else $error("scan accumulate without read");
    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_IDLE))
        else $error("execute step longer than one cycle");

endmodule
`default_nettype wire

### rtl/core/cwpe_dp.sv
// datapath: link state, slot ring store and result registers
`default_nettype none
module cwpe_dp
    import cwpe_pkg::*;
#(
    parameter int RING_SLOTS   = DEF_RING_SLOTS,
    parameter int SEND_BUFFERS = DEF_SEND_BUFFERS
)(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  wire  [12:0] i_payload_bytes,
    input  wire  [7:0]  i_ack_threshold,
    input  wire  [3:0]  i_max_outstanding,
    input  wire  [2:0]  i_action,
    input  wire  [23:0] i_message_length,
    input  wire  [3:0]  i_outstanding_writes,
    input  wire  [2:0]  i_arrival_slot,
    input  wire  [12:0] i_arrival_offset,
    input  wire  [7:0]  i_arrival_ack,
    input  wire         i_arrival_last,
    input  wire  [15:0] i_ack_count,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [12:0] o_tx_offset,
    output logic [12:0] o_tx_size,
    output logic [7:0]  o_tx_ack,
    output logic        o_tx_last,
    output logic [2:0]  o_tx_remote_slot,
    output logic        o_tx_local_buffer,
    output logic [23:0] o_rx_size,
    output logic        o_ack_out_valid,
    output logic [7:0]  o_ack_out_count,
    output logic [15:0] o_credits_left
);

    localparam int SW = $clog2(RING_SLOTS);
    localparam int BW = (SEND_BUFFERS > 1) ? $clog2(SEND_BUFFERS) : 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(RING_SLOTS - 1);
    localparam logic [BW-1:0] BUF_LAST  = BW'(SEND_BUFFERS - 1);

    // captured request
    logic [2:0]  r_action;
    logic [23:0] r_len;
    logic [3:0]  r_outst;
    logic [2:0]  r_aslot;
    logic [12:0] r_aoff;
    logic [7:0]  r_aack;
    logic        r_alast;
    logic [15:0] r_ackcnt;

    // link state
    logic [15:0]    r_credits, n_credits;
    logic [7:0]     r_unacked, n_unacked;
    logic [SW-1:0]  r_next_out, n_next_out;
    logic [SW-1:0]  r_next_in, n_next_in;
    logic [BW-1:0]  r_buf, n_buf;
    logic [23:0]    r_remain, n_remain;
    logic [23:0]    r_total, n_total;
    logic [SW-1:0]  r_idx;

    logic [RING_SLOTS-1:0] r_full, r_last, r_live;

    // ack and offset per slot
    logic [20:0] r_mem [RING_SLOTS];
    logic [20:0] r_rd_data;
    logic [SW-1:0] rd_addr;

    // results
    logic [2:0]  n_status;
    logic [12:0] n_tx_offset, n_tx_size;
    logic [7:0]  n_tx_ack;
    logic        n_tx_last;
    logic [2:0]  n_tx_slot;
    logic        n_tx_buf;
    logic [23:0] n_rx_size;
    logic        n_ack_valid;
    logic [7:0]  n_ack_count;

    logic [SW+2:0] aslot_wide;
    logic [SW-1:0] aslot_idx;
    logic          aslot_ok;
    logic [SW+2:0] out_wide;
    logic [12:0]   pay;
    logic [12:0]   off, size;
    logic [24:0]   tot;
    logic [7:0]    unacked_inc;
    logic [BW+7:0] buf_wide;

    assign aslot_wide = {{SW{1'b0}}, r_aslot};
    assign aslot_idx  = aslot_wide[SW-1:0];
    assign aslot_ok   = aslot_wide < (SW+3)'(RING_SLOTS);
    assign out_wide   = {3'b000, r_next_out};
    assign buf_wide   = {8'd0, r_buf};
    assign pay        = (i_payload_bytes == 13'd0) ? 13'd1 : i_payload_bytes;
    assign rd_addr    = i_cmd.scan_rd ? r_idx : r_next_in;

    assign o_sts.need_scan = (r_action == ACT_SEND) && (r_remain != 24'd0)
                             && (r_credits <= 16'd1);
    assign o_sts.scan_last = (r_idx == SLOT_LAST);

    always_comb begin
        n_credits   = r_credits;
        n_unacked   = r_unacked;
        n_next_out  = r_next_out;
        n_next_in   = r_next_in;
        n_buf       = r_buf;
        n_remain    = r_remain;
        n_total     = r_total;
        n_status    = ST_NONE;
        n_tx_offset = '0;
        n_tx_size   = '0;
        n_tx_ack    = '0;
        n_tx_last   = 1'b0;
        n_tx_slot   = '0;
        n_tx_buf    = 1'b0;
        n_rx_size   = '0;
        n_ack_valid = 1'b0;
        n_ack_count = '0;
        off         = '0;
        size        = '0;
        tot         = '0;
        unacked_inc = (r_unacked == 8'hFF) ? 8'hFF : r_unacked + 8'd1;

        if (i_cmd.scan_acc && r_full[r_idx] && r_live[r_idx]) begin
            n_credits = sat_add16(r_credits, {8'd0, r_rd_data[20:13]});
        end

        if (i_cmd.exec) begin
            case (r_action)
                ACT_POST: begin
                    n_remain = r_len;
                    n_buf    = '0;
                    n_status = ST_ACCEPTED;
                end
                ACT_SEND: begin
                    if (r_remain == 24'd0) begin
                        n_status = (r_outst != 4'd0) ? ST_BLOCK : ST_DONE;
                    end else if (r_credits <= 16'd1 || r_outst >= i_max_outstanding) begin
                        n_status = ST_BLOCK;
                    end else begin
                        // last packet right-aligned so it holds what remains
                        off  = (r_remain > {11'd0, pay}) ? 13'd0 : pay - r_remain[12:0];
                        size = pay - off;
                        n_remain    = r_remain - {11'd0, size};
                        n_status    = ST_SENT;
                        n_tx_offset = off;
                        n_tx_size   = size;
                        n_tx_ack    = r_unacked;
                        n_tx_last   = (n_remain == 24'd0);
                        n_tx_slot   = out_wide[2:0];
                        n_tx_buf    = buf_wide[0];
                        n_unacked   = '0;
                        n_buf       = (r_buf == BUF_LAST) ? '0 : r_buf + 1'b1;
                        n_next_out  = (r_next_out == SLOT_LAST) ? '0 : r_next_out + 1'b1;
                        n_credits   = r_credits - 16'd1;
                    end
                end
                ACT_ARRIVE: begin
                    n_status = aslot_ok ? ST_ACCEPTED : ST_NONE;
                end
                ACT_CONSUME: begin
                    if (r_full[r_next_in]) begin
                        off  = r_rd_data[12:0];
                        size = (off > pay) ? 13'd0 : pay - off;
                        tot  = {1'b0, r_total} + {12'd0, size};
                        n_total   = tot[24] ? TOTAL_MAX : tot[23:0];
                        n_credits = sat_add16(r_credits,
                                    r_live[r_next_in] ? {8'd0, r_rd_data[20:13]} : 16'd0);
                        n_unacked = unacked_inc;
                        if (unacked_inc > i_ack_threshold) begin
                            n_ack_valid = 1'b1;
                            n_ack_count = unacked_inc;
                            n_unacked   = '0;
                        end
                        n_next_in = (r_next_in == SLOT_LAST) ? '0 : r_next_in + 1'b1;
                        if (r_last[r_next_in]) begin
                            n_rx_size = n_total;
                            n_total   = '0;
                            n_status  = ST_COMPLETE;
                        end else begin
                            n_rx_size = {11'd0, size};
                            n_status  = ST_CONSUMED;
                        end
                    end
                end
                ACT_ACK: begin
                    n_credits = sat_add16(r_credits, r_ackcnt);
                    n_status  = ST_ACCEPTED;
                end
                default: n_status = ST_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_action;
            r_len    <= i_message_length;
            r_outst  <= i_outstanding_writes;
            r_aslot  <= i_arrival_slot;
            r_aoff   <= i_arrival_offset;
            r_aack   <= i_arrival_ack;
            r_alast  <= i_arrival_last;
            r_ackcnt <= i_ack_count;
        end
        if (i_cmd.exec && r_action == ACT_ARRIVE && aslot_ok) begin
            r_mem[aslot_idx] <= {r_aack, r_aoff};
        end
        r_rd_data <= r_mem[rd_addr];
        if (i_cmd.exec) begin
            o_status          <= n_status;
            o_tx_offset       <= n_tx_offset;
            o_tx_size         <= n_tx_size;
            o_tx_ack          <= n_tx_ack;
            o_tx_last         <= n_tx_last;
            o_tx_remote_slot  <= n_tx_slot;
            o_tx_local_buffer <= n_tx_buf;
            o_rx_size         <= n_rx_size;
            o_ack_out_valid   <= n_ack_valid;
            o_ack_out_count   <= n_ack_count;
            o_credits_left    <= n_credits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credits  <= 16'(RING_SLOTS);
            r_unacked  <= '0;
            r_next_out <= SW'(1);
            r_next_in  <= SW'(1);
            r_buf      <= '0;
            r_remain   <= '0;
            r_total    <= '0;
            r_idx      <= '0;
            r_full     <= '0;
            r_last     <= '0;
            r_live     <= '0;
            o_done     <= 1'b0;
        end else begin
            r_credits  <= n_credits;
            r_unacked  <= n_unacked;
            r_next_out <= n_next_out;
            r_next_in  <= n_next_in;
            r_buf      <= n_buf;
            r_remain   <= n_remain;
            r_total    <= n_total;
            o_done     <= i_cmd.exec;
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
            end else if (i_cmd.scan_acc && !o_sts.scan_last) begin
                r_idx <= r_idx + 1'b1;
            end
            // reclaimed ack reads as zero from now on
            if (i_cmd.scan_acc && r_full[r_idx]) begin
                r_live[r_idx] <= 1'b0;
            end
            if (i_cmd.exec && r_action == ACT_ARRIVE && aslot_ok) begin
                r_full[aslot_idx] <= 1'b1;
                r_last[aslot_idx] <= r_alast;
                r_live[aslot_idx] <= 1'b1;
            end
            if (i_cmd.exec && r_action == ACT_CONSUME && r_full[r_next_in]) begin
                r_full[r_next_in] <= 1'b0;
                r_last[r_next_in] <= 1'b0;
                r_live[r_next_in] <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/credit_window_packet_engine.sv
// top level: register port, sequencer and datapath of the credit window engine
//
//  channel   | handshake                   | payload
//  request   | start, busy (accept: start & !busy) | i_action .. i_ack_count
//  result    | o_done, one-cycle strobe    | o_status .. o_credits_left
//  register  | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// a request without a credit scan goes through the prep and execute steps, then o_done.
// a send with data left that finds at most one credit first scans the ring, a read
// and an accumulate step per slot, as the slot store has a single read port.
// busy stays high until the result strobe; one request is in flight at a time.
// reset is synchronous; the slot store itself is not cleared, its full bits are.
// results cannot be stalled; the strobe is lost if not taken, the result outputs hold until the next result.
`default_nettype none
module credit_window_packet_engine
    import cwpe_pkg::*;
#(
    parameter int RING_SLOTS   = DEF_RING_SLOTS,
    parameter int SEND_BUFFERS = DEF_SEND_BUFFERS
)(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  i_action,
    input  wire  [23:0] i_message_length,
    input  wire  [3:0]  i_outstanding_writes,
    input  wire  [2:0]  i_arrival_slot,
    input  wire  [12:0] i_arrival_offset,
    input  wire  [7:0]  i_arrival_ack,
    input  wire         i_arrival_last,
    input  wire  [15:0] i_ack_count,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [12:0] o_tx_offset,
    output logic [12:0] o_tx_size,
    output logic [7:0]  o_tx_ack,
    output logic        o_tx_last,
    output logic [2:0]  o_tx_remote_slot,
    output logic        o_tx_local_buffer,
    output logic [23:0] o_rx_size,
    output logic        o_ack_out_valid,
    output logic [7:0]  o_ack_out_count,
    output logic [15:0] o_credits_left,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0] r_payload;
    logic [7:0]  r_threshold;
    logic [3:0]  r_max_out;
    logic        wr_en;
    t_cmd        cmd;
    t_sts        sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload   <= PAYLOAD_RESET;
            r_threshold <= THRESHOLD_RESET;
            r_max_out   <= MAX_OUT_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_PAYLOAD:   r_payload   <= pwdata[12:0];
                REG_THRESHOLD: r_threshold <= pwdata[7:0];
                REG_MAX_OUT:   r_max_out   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PAYLOAD:   prdata = {19'd0, r_payload};
            REG_THRESHOLD: prdata = {24'd0, r_threshold};
            REG_MAX_OUT:   prdata = {28'd0, r_max_out};
            default:       prdata = '0;
        endcase
    end

    cwpe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    cwpe_dp #(
        .RING_SLOTS   (RING_SLOTS),
        .SEND_BUFFERS (SEND_BUFFERS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_payload_bytes      (r_payload),
        .i_ack_threshold      (r_threshold),
        .i_max_outstanding    (r_max_out),
        .i_action             (i_action),
        .i_message_length     (i_message_length),
        .i_outstanding_writes (i_outstanding_writes),
        .i_arrival_slot       (i_arrival_slot),
        .i_arrival_offset     (i_arrival_offset),
        .i_arrival_ack        (i_arrival_ack),
        .i_arrival_last       (i_arrival_last),
        .i_ack_count          (i_ack_count),
        .o_done               (o_done),
        .o_status             (o_status),
        .o_tx_offset          (o_tx_offset),
        .o_tx_size            (o_tx_size),
        .o_tx_ack             (o_tx_ack),
        .o_tx_last            (o_tx_last),
        .o_tx_remote_slot     (o_tx_remote_slot),
        .o_tx_local_buffer    (o_tx_local_buffer),
        .o_rx_size            (o_rx_size),
        .o_ack_out_valid      (o_ack_out_valid),
        .o_ack_out_count      (o_ack_out_count),
        .o_credits_left       (o_credits_left)
    );

endmodule
`default_nettype wire

### dv/tb.sv
// self-checking testbench for the credit window packet engine
`default_nettype none
module tb
    import cwpe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 40;

    typedef struct packed {
        logic [2:0]  action;
        logic [23:0] msg_len;
        logic [3:0]  outstanding;
        logic [2:0]  slot;
        logic [12:0] offset;
        logic [7:0]  ack;
        logic        last;
        logic [15:0] ack_count;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] tx_offset;
        logic [12:0] tx_size;
        logic [7:0]  tx_ack;
        logic        tx_last;
        logic [2:0]  tx_slot;
        logic        tx_buf;
        logic [23:0] rx_size;
        logic        ack_valid;
        logic [7:0]  ack_cnt;
        logic [15:0] credits;
    } t_res;

    class cwpe_scoreboard;
        logic [12:0] payload_cfg;
        logic [7:0]  thresh_cfg;
        logic [3:0]  max_out_cfg;
        int unsigned credits, unacked, out_slot, in_slot, buf_idx, remaining, rx_total;
        bit          full[8];
        bit          last[8];
        int unsigned slot_ack[8];
        int unsigned slot_off[8];
        t_res        expected_q[$];
        int          mismatches, results_seen, packets_sent, msgs_done;

        function new();
            payload_cfg = PAYLOAD_RESET;
            thresh_cfg  = THRESHOLD_RESET;
            max_out_cfg = MAX_OUT_RESET;
            credits = 8; unacked = 0; out_slot = 1; in_slot = 1;
            buf_idx = 0; remaining = 0; rx_total = 0;
            foreach (full[i]) begin
                full[i] = 1'b0; last[i] = 1'b0; slot_ack[i] = 0; slot_off[i] = 0;
            end
        endfunction

        function void add_credits(int unsigned n);
            credits = (credits + n > 65535) ? 65535 : credits + n;
        endfunction

        function void note(t_req r);
            t_res        e;
            int unsigned p, off, sz, t;
            e = '0;
            e.status = ST_NONE;
            p = (payload_cfg == 0) ? 1 : payload_cfg;
            case (r.action)
                ACT_POST: begin
                    remaining = r.msg_len;
                    buf_idx   = 0;
                    e.status  = ST_ACCEPTED;
                end
                ACT_SEND: begin
                    if (remaining == 0) begin
                        e.status = (r.outstanding != 0) ? ST_BLOCK : ST_DONE;
                    end else begin
                        // reclaim acks parked in unconsumed slots
                        if (credits <= 1) begin
                            foreach (full[i]) if (full[i]) begin
                                add_credits(slot_ack[i]);
                                slot_ack[i] = 0;
                            end
                        end
                        if (credits <= 1 || r.outstanding >= max_out_cfg) begin
                            e.status = ST_BLOCK;
                        end else begin
                            off = (remaining > p) ? 0 : p - remaining;
                            sz  = p - off;
                            remaining   -= sz;
                            e.status    = ST_SENT;
                            e.tx_offset = 13'(off);
                            e.tx_size   = 13'(sz);
                            e.tx_ack    = 8'(unacked);
                            e.tx_last   = (remaining == 0);
                            e.tx_slot   = 3'(out_slot);
                            e.tx_buf    = 1'(buf_idx);
                            unacked  = 0;
                            buf_idx  = (buf_idx + 1) % 2;
                            out_slot = (out_slot + 1) % 8;
                            credits--;
                            packets_sent++;
                        end
                    end
                end
                ACT_ARRIVE: begin
                    full[r.slot]     = 1'b1;
                    last[r.slot]     = r.last;
                    slot_ack[r.slot] = r.ack;
                    slot_off[r.slot] = r.offset;
                    e.status = ST_ACCEPTED;
                end
                ACT_CONSUME: begin
                    if (full[in_slot]) begin
                        sz = (slot_off[in_slot] > p) ? 0 : p - slot_off[in_slot];
                        t  = rx_total + sz;
                        rx_total = (t > 24'hFFFFFF) ? 24'hFFFFFF : t;
                        add_credits(slot_ack[in_slot]);
                        slot_ack[in_slot] = 0;
                        full[in_slot] = 1'b0;
                        if (unacked < 255) unacked++;
                        if (unacked > thresh_cfg) begin
                            e.ack_valid = 1'b1;
                            e.ack_cnt   = 8'(unacked);
                            unacked = 0;
                        end
                        if (last[in_slot]) begin
                            last[in_slot] = 1'b0;
                            e.status  = ST_COMPLETE;
                            e.rx_size = 24'(rx_total);
                            rx_total  = 0;
                            msgs_done++;
                        end else begin
                            e.status  = ST_CONSUMED;
                            e.rx_size = 24'(sz);
                        end
                        in_slot = (in_slot + 1) % 8;
                    end
                end
                ACT_ACK: begin
                    add_credits(r.ack_count);
                    e.status = ST_ACCEPTED;
                end
                default: ;
            endcase
            e.credits = 16'(credits);
            expected_q.push_back(e);
        endfunction

        function void check(t_res got);
            t_res e;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            e = expected_q.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p\n          actual   %p", e, got);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, start, busy;
    t_req        drv;
    logic        o_done, o_tx_last, o_tx_local_buffer, o_ack_out_valid;
    logic [2:0]  o_status, o_tx_remote_slot;
    logic [12:0] o_tx_offset, o_tx_size;
    logic [7:0]  o_tx_ack, o_ack_out_count;
    logic [23:0] o_rx_size;
    logic [15:0] o_credits_left;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    cwpe_scoreboard sb;
    int idle_pct;
    int idle_cycles;
    int accepted;

    credit_window_packet_engine u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(drv.action), .i_message_length(drv.msg_len),
        .i_outstanding_writes(drv.outstanding), .i_arrival_slot(drv.slot),
        .i_arrival_offset(drv.offset), .i_arrival_ack(drv.ack),
        .i_arrival_last(drv.last), .i_ack_count(drv.ack_count),
        .o_done(o_done), .o_status(o_status), .o_tx_offset(o_tx_offset),
        .o_tx_size(o_tx_size), .o_tx_ack(o_tx_ack), .o_tx_last(o_tx_last),
        .o_tx_remote_slot(o_tx_remote_slot), .o_tx_local_buffer(o_tx_local_buffer),
        .o_rx_size(o_rx_size), .o_ack_out_valid(o_ack_out_valid),
        .o_ack_out_count(o_ack_out_count), .o_credits_left(o_credits_left),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check({o_status, o_tx_offset, o_tx_size, o_tx_ack, o_tx_last,
                      o_tx_remote_slot, o_tx_local_buffer, o_rx_size,
                      o_ack_out_valid, o_ack_out_count, o_credits_left});
    end

    // watchdog: cycles with no request taken, no result seen and no register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic issue(t_req r);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge i_clk);
        @(negedge i_clk);
        drv   = r;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note(r);
        accepted++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_empty();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain();
        wait_empty();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_PAYLOAD:   sb.payload_cfg = val[12:0];
            REG_THRESHOLD: sb.thresh_cfg  = val[7:0];
            REG_MAX_OUT:   sb.max_out_cfg = val[3:0];
            default: ;
        endcase
    endtask

    function automatic t_req mk(logic [2:0] act);
        t_req r;
        r = '0;
        r.action = act;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req        r;
        logic [95:0] raw;
        int          pick;
        int unsigned p;
        raw = {$urandom, $urandom, $urandom};
        r = raw[$bits(t_req)-1:0];
        p = (sb.payload_cfg == 0) ? 1 : sb.payload_cfg;
        pick = $urandom_range(99);
        if (pick < 8) begin
            r.action = ACT_POST;
            case ($urandom_range(9))
                0: r.msg_len = 24'($urandom);
                1: r.msg_len = 24'($urandom_range(255));
                default: r.msg_len = 24'($urandom_range(p * 5));
            endcase
        end else if (pick < 45) begin
            r.action = ACT_SEND;
            if ($urandom_range(3) != 0) r.outstanding = 4'($urandom_range(2));
        end else if (pick < 68) begin
            r.action = ACT_ARRIVE;
            if ($urandom_range(4) != 0) r.slot = 3'(sb.in_slot);
            if ($urandom_range(2) != 0) r.offset = 13'($urandom_range(p));
            if ($urandom_range(3) != 0) r.ack = 8'($urandom_range(3));
            r.last = ($urandom_range(3) == 0);
        end else if (pick < 90) begin
            r.action = ACT_CONSUME;
        end else if (pick < 97) begin
            r.action = ACT_ACK;
            if ($urandom_range(9) != 0) r.ack_count = 16'($urandom_range(4));
        end else begin
            r.action = 3'($urandom_range(7, 5));
        end
        return r;
    endfunction

    task automatic random_run(int n);
        for (int k = 0; k < n; k++) begin
            if (k == n / 2) wait_empty();
            issue(random_req());
        end
    endtask

    initial begin
        t_req r;
        sb = new();
        start = 1'b0; drv = '0; idle_pct = 0; accepted = 0; idle_cycles = 0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty sends, segmenting, ring arrivals, saturation, bad actions
        r = mk(ACT_SEND); issue(r);
        r.outstanding = 4'hF; issue(r);
        r = mk(ACT_POST); r.msg_len = 24'd20000; issue(r);
        r = mk(ACT_SEND); repeat (3) issue(r);
        r = mk(ACT_POST); r.msg_len = 24'hFFFFFF; issue(r);
        r = mk(ACT_SEND); r.outstanding = 4'hF; issue(r);
        r.outstanding = 4'd0; repeat (6) issue(r);
        r = mk(ACT_ARRIVE); r.slot = 3'd1; r.ack = 8'hFF; issue(r);
        r.slot = 3'd2; r.offset = 13'h1FFF; r.ack = 8'hFF; r.last = 1'b1; issue(r);
        r = mk(ACT_SEND); issue(r);
        r = mk(ACT_CONSUME); repeat (3) issue(r);
        r = mk(ACT_ACK); r.ack_count = 16'hFFFF; repeat (2) issue(r);
        for (int a = 5; a < 8; a++) issue(mk(3'(a)));
        drain();

        reg_write(REG_PAYLOAD, 0);
        reg_write(REG_THRESHOLD, 1);
        reg_write(REG_MAX_OUT, 1);
        idle_pct = 15;
        random_run(350);
        drain();

        reg_write(REG_PAYLOAD, 8188);
        reg_write(REG_THRESHOLD, 255);
        reg_write(REG_MAX_OUT, 15);
        idle_pct = 73;
        random_run(300);
        drain();

        reg_write(REG_PAYLOAD, 100);
        reg_write(REG_THRESHOLD, 3);
        reg_write(REG_MAX_OUT, 2);
        idle_pct = 0;
        random_run(350);
        drain();

        $display("requests %0d, results %0d, packets sent %0d, messages completed %0d",
                 accepted, sb.results_seen, sb.packets_sent, sb.msgs_done);
        $display("mismatches %0d over four register settings", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
